// ===== hw/rtl/plr_pkg.sv =====
// shared types, constants and helpers for the positional record list
package plr_pkg;

  // list geometry
  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned ADDR_W     = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned NUM_W      = 56;
  localparam int unsigned LOW_W      = 64;
  localparam int unsigned MID_W      = 64;
  localparam int unsigned HIGH_W     = 24;
  localparam int unsigned NAME_W     = LOW_W + MID_W + HIGH_W;
  localparam int unsigned NAME_BYTES = NAME_W / 8;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned FPOS_W     = 9;
  localparam int unsigned ECNT_W     = 9;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 2'd0,
    CMD_REMOVE      = 2'd1,
    CMD_FIND_NAME   = 2'd2,
    CMD_FIND_NUMBER = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // one stored record, name byte 0 in the lowest bits
  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [NAME_W-1:0] name;
  } record_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    walk;
    logic    place;
    logic    shrink;
    logic    take;
    logic    emit;
    status_e code;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e op;
    logic pos_ok;
    logic full;
    logic walk_idle;
    logic hit;
    logic out_free;
  } dp_stat_t;

  // text key: clear every byte from the first zero byte onward
  function automatic logic [NAME_W-1:0] cut_text(input logic [NAME_W-1:0] v);
    logic              ended;
    logic [NAME_W-1:0] r;
    ended = 1'b0;
    r     = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (v[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/plr_req_if.sv =====
// request channel: one list operation per transfer
interface plr_req_if;
  logic                       valid;
  logic                       ready;
  logic [plr_pkg::CMD_W-1:0]  command;
  logic [plr_pkg::POS_W-1:0]  position;
  logic [plr_pkg::NUM_W-1:0]  record_number;
  logic [plr_pkg::LOW_W-1:0]  name_low;
  logic [plr_pkg::MID_W-1:0]  name_mid;
  logic [plr_pkg::HIGH_W-1:0] name_high;

  modport source (
    output valid, command, position, record_number, name_low, name_mid, name_high,
    input  ready
  );
  modport sink (
    input  valid, command, position, record_number, name_low, name_mid, name_high,
    output ready
  );
endinterface

// ===== hw/rtl/plr_rsp_if.sv =====
// response channel: one result per transfer
interface plr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [plr_pkg::STAT_W-1:0] status;
  logic [plr_pkg::FPOS_W-1:0] found_position;
  logic [plr_pkg::NUM_W-1:0]  found_number;
  logic [plr_pkg::LOW_W-1:0]  found_name_low;
  logic [plr_pkg::MID_W-1:0]  found_name_mid;
  logic [plr_pkg::HIGH_W-1:0] found_name_high;
  logic [plr_pkg::ECNT_W-1:0] entry_count;

  modport source (
    output valid, status, found_position, found_number, found_name_low,
           found_name_mid, found_name_high, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, found_position, found_number, found_name_low,
           found_name_mid, found_name_high, entry_count,
    output ready
  );
endinterface

// ===== hw/rtl/positional_record_list.sv =====
// top level of the positional record list
//
//   port    dir  contents
//   req_i   in   command, position, record number, name (three words)
//   rsp_o   out  status, found position and record, entry count
//
// one operation at a time; the record memory is walked one entry per cycle
// through its single read and single write port. insert and remove walk from
// the position to the end, a find until a hit or the end. the next transfer is
// taken in the cycle after the result is loaded. reset clears the entry count
// and control state, with no memory pass. a loaded result waits in the output
// register; only the next result can stall
module positional_record_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  plr_req_if.sink    req_i,
  plr_rsp_if.source  rsp_o
);

  plr_pkg::ctrl_cmd_t cmd;
  plr_pkg::dp_stat_t  stat;

  // sequencer
  plr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // memory and compare datapath
  plr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .command_i         (req_i.command),
    .position_i        (req_i.position),
    .record_number_i   (req_i.record_number),
    .name_low_i        (req_i.name_low),
    .name_mid_i        (req_i.name_mid),
    .name_high_i       (req_i.name_high),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .status_o          (rsp_o.status),
    .found_position_o  (rsp_o.found_position),
    .found_number_o    (rsp_o.found_number),
    .found_name_low_o  (rsp_o.found_name_low),
    .found_name_mid_o  (rsp_o.found_name_mid),
    .found_name_high_o (rsp_o.found_name_high),
    .entry_count_o     (rsp_o.entry_count)
  );

endmodule

// ===== hw/rtl/plr_datapath.sv =====
// record memory, walk pointer, key compare and result register
module plr_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plr_pkg::ctrl_cmd_t         cmd_i,
  output plr_pkg::dp_stat_t          stat_o,
  input  logic [plr_pkg::CMD_W-1:0]  command_i,
  input  logic [plr_pkg::POS_W-1:0]  position_i,
  input  logic [plr_pkg::NUM_W-1:0]  record_number_i,
  input  logic [plr_pkg::LOW_W-1:0]  name_low_i,
  input  logic [plr_pkg::MID_W-1:0]  name_mid_i,
  input  logic [plr_pkg::HIGH_W-1:0] name_high_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [plr_pkg::STAT_W-1:0] status_o,
  output logic [plr_pkg::FPOS_W-1:0] found_position_o,
  output logic [plr_pkg::NUM_W-1:0]  found_number_o,
  output logic [plr_pkg::LOW_W-1:0]  found_name_low_o,
  output logic [plr_pkg::MID_W-1:0]  found_name_mid_o,
  output logic [plr_pkg::HIGH_W-1:0] found_name_high_o,
  output logic [plr_pkg::ECNT_W-1:0] entry_count_o
);

  // record store
  plr_pkg::record_t mem [plr_pkg::LIST_DEPTH];

  plr_pkg::cmd_e                 op_q;
  logic [plr_pkg::POS_W-1:0]     pos_q;
  plr_pkg::record_t              key_q;
  logic [plr_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [plr_pkg::CNT_W-1:0]     ptr_q, ptr_d;
  logic                          pend_q, pend_d;
  logic [plr_pkg::ADDR_W-1:0]    pend_addr_q, pend_addr_d;
  plr_pkg::record_t              rd_data_q;
  plr_pkg::record_t              found_q;
  logic [plr_pkg::CNT_W-1:0]     fpos_q;
  logic                          out_valid_q;
  plr_pkg::status_e              out_status_q;
  logic [plr_pkg::CNT_W-1:0]     out_fpos_q;
  plr_pkg::record_t              out_rec_q;
  logic [plr_pkg::CNT_W-1:0]     out_cnt_q;

  logic                          more;
  logic                          rd_en;
  logic [plr_pkg::ADDR_W-1:0]    rd_addr;
  logic                          wr_en;
  logic [plr_pkg::ADDR_W-1:0]    wr_addr;
  plr_pkg::record_t              wr_data;
  logic                          match;
  logic                          shifting;
  plr_pkg::record_t              key_in;

  // input key with bytes past the terminator cleared
  always_comb begin
    key_in.number = plr_pkg::NUM_W'(plr_pkg::cut_text(plr_pkg::NAME_W'(record_number_i)));
    key_in.name   = plr_pkg::cut_text({name_high_i, name_mid_i, name_low_i});
  end

  // walk pointer: next read address and where its data goes
  always_comb begin
    more        = 1'b0;
    rd_addr     = plr_pkg::ADDR_W'(ptr_q);
    pend_addr_d = plr_pkg::ADDR_W'(ptr_q);
    ptr_d       = ptr_q + plr_pkg::CNT_W'(1);
    case (op_q)
      plr_pkg::CMD_INSERT: begin
        more        = plr_pkg::POS_W'(ptr_q) >= pos_q;
        rd_addr     = plr_pkg::ADDR_W'(ptr_q - plr_pkg::CNT_W'(1));
        pend_addr_d = plr_pkg::ADDR_W'(ptr_q);
        ptr_d       = ptr_q - plr_pkg::CNT_W'(1);
      end
      plr_pkg::CMD_REMOVE: begin
        more        = ptr_q < cnt_q;
        pend_addr_d = plr_pkg::ADDR_W'(ptr_q - plr_pkg::CNT_W'(1));
      end
      default: begin
        more = ptr_q < cnt_q;
      end
    endcase
    rd_en  = cmd_i.walk && more;
    pend_d = rd_en;
  end

  // write port: new record on place, otherwise the shifted entry
  always_comb begin
    shifting = (op_q == plr_pkg::CMD_INSERT) || (op_q == plr_pkg::CMD_REMOVE);
    wr_en    = cmd_i.place || (pend_q && shifting);
    wr_addr  = pend_addr_q;
    wr_data  = rd_data_q;
    if (cmd_i.place) begin
      wr_addr = plr_pkg::ADDR_W'(pos_q - plr_pkg::POS_W'(1));
      wr_data = key_q;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // key compare on the entry read last cycle
  always_comb begin
    if (op_q == plr_pkg::CMD_FIND_NAME) begin
      match = rd_data_q.name == key_q.name;
    end else begin
      match = rd_data_q.number == key_q.number;
    end
  end

  // record count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.place) begin
      cnt_d = cnt_q + plr_pkg::CNT_W'(1);
    end else if (cmd_i.shrink) begin
      cnt_d = cnt_q - plr_pkg::CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation capture, pointer and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= plr_pkg::cmd_e'(command_i);
      pos_q   <= position_i;
      key_q   <= key_in;
      found_q <= '0;
      fpos_q  <= '0;
      case (plr_pkg::cmd_e'(command_i))
        plr_pkg::CMD_INSERT: ptr_q <= cnt_q;
        plr_pkg::CMD_REMOVE: ptr_q <= plr_pkg::CNT_W'(position_i);
        default:             ptr_q <= '0;
      endcase
    end else if (rd_en) begin
      ptr_q <= ptr_d;
    end
    if (rd_en) pend_addr_q <= pend_addr_d;
    if (cmd_i.take) begin
      found_q <= rd_data_q;
      fpos_q  <= plr_pkg::CNT_W'(pend_addr_q) + plr_pkg::CNT_W'(1);
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.code;
      out_fpos_q   <= fpos_q;
      out_rec_q    <= found_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // status towards the controller
  always_comb begin
    stat_o.op        = op_q;
    stat_o.pos_ok    = 1'b0;
    case (op_q)
      plr_pkg::CMD_INSERT:
        stat_o.pos_ok = (pos_q != '0) &&
                        (pos_q <= plr_pkg::POS_W'(cnt_q) + plr_pkg::POS_W'(1));
      plr_pkg::CMD_REMOVE:
        stat_o.pos_ok = (pos_q != '0) && (pos_q <= plr_pkg::POS_W'(cnt_q));
      default:
        stat_o.pos_ok = 1'b1;
    endcase
    stat_o.full      = cnt_q == plr_pkg::CNT_W'(plr_pkg::LIST_DEPTH);
    stat_o.walk_idle = !more && !pend_q;
    stat_o.hit       = pend_q && !shifting && match;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // result outputs
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign found_position_o  = plr_pkg::FPOS_W'(out_fpos_q);
  assign found_number_o    = out_rec_q.number;
  assign found_name_low_o  = out_rec_q.name[plr_pkg::LOW_W-1:0];
  assign found_name_mid_o  = out_rec_q.name[plr_pkg::LOW_W +: plr_pkg::MID_W];
  assign found_name_high_o = out_rec_q.name[plr_pkg::LOW_W + plr_pkg::MID_W +: plr_pkg::HIGH_W];
  assign entry_count_o     = plr_pkg::ECNT_W'(out_cnt_q);

endmodule

// ===== hw/rtl/plr_ctrl.sv =====
// operation sequencer for the positional record list
module plr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  plr_pkg::dp_stat_t   stat_i,
  output plr_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SEARCH,
    S_RESP
  } state_e;

  state_e           state_q;
  plr_pkg::status_e code_q;

  // command decode
  always_comb begin
    req_ready_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.code   = code_q;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_SHIFT_UP: begin
        cmd_o.walk  = 1'b1;
        cmd_o.place = stat_i.walk_idle;
      end
      S_SHIFT_DOWN: begin
        cmd_o.walk   = 1'b1;
        cmd_o.shrink = stat_i.walk_idle;
      end
      S_SEARCH: begin
        cmd_o.walk = 1'b1;
        cmd_o.take = stat_i.hit;
      end
      S_RESP: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

  // state and result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= plr_pkg::ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          case (stat_i.op)
            plr_pkg::CMD_INSERT: begin
              if (!stat_i.pos_ok) begin
                code_q  <= plr_pkg::ST_MISS;
                state_q <= S_RESP;
              end else if (stat_i.full) begin
                code_q  <= plr_pkg::ST_FULL;
                state_q <= S_RESP;
              end else begin
                state_q <= S_SHIFT_UP;
              end
            end
            plr_pkg::CMD_REMOVE: begin
              if (!stat_i.pos_ok) begin
                code_q  <= plr_pkg::ST_MISS;
                state_q <= S_RESP;
              end else begin
                state_q <= S_SHIFT_DOWN;
              end
            end
            default: state_q <= S_SEARCH;
          endcase
        end
        S_SHIFT_UP, S_SHIFT_DOWN: begin
          if (stat_i.walk_idle) begin
            code_q  <= plr_pkg::ST_OK;
            state_q <= S_RESP;
          end
        end
        S_SEARCH: begin
          if (stat_i.hit) begin
            code_q  <= plr_pkg::ST_OK;
            state_q <= S_RESP;
          end else if (stat_i.walk_idle) begin
            code_q  <= plr_pkg::ST_MISS;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
